// ===== rtl/edt_pkg.sv =====
// ----------------------------------------------------------------------------
// Exception dispatch table package
// Shared widths, codes and the command record passed from front to back.
// ----------------------------------------------------------------------------
package edt_pkg;

  localparam int unsigned CodeW  = 12;
  localparam int unsigned WordW  = 32;
  localparam int unsigned SlotW  = 7;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CfgIdxW = 2;

  // Depth of the command queue between front and back
  localparam int unsigned CmdQueueDepth = 2;

  localparam logic [CodeW-1:0] UserBreakReset   = 12'd480;
  localparam logic [CodeW-1:0] UnknownTypeReset = 12'd4095;

  typedef enum logic {
    FUNC_REGISTER = 1'b0,
    FUNC_DISPATCH = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    EXC_GENERAL   = 2'd0,
    EXC_CACHE     = 2'd1,
    EXC_INTERRUPT = 2'd2,
    EXC_UNKNOWN   = 2'd3
  } exc_type_e;

  typedef enum logic [KindW-1:0] {
    KIND_REG_REPLY = 2'd0,
    KIND_MATCH     = 2'd1,
    KIND_SUMMARY   = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_USER_BREAK   = 2'd0,
    CFG_UNKNOWN_TYPE = 2'd1
  } cfg_idx_e;

  // Which counters a dispatch bumps
  typedef enum logic [2:0] {
    CNT_GENERAL,
    CNT_GENERAL_BREAK,
    CNT_CACHE,
    CNT_INTERRUPT,
    CNT_ODD
  } cnt_sel_e;

  // Classified command. For a register item code is the entry code and
  // word_a/word_b the entry masks; for a dispatch, code is the selected
  // event code and word_a/word_b the status words.
  typedef struct packed {
    func_e             func;
    logic [CodeW-1:0]  code;
    logic [WordW-1:0]  word_a;
    logic [WordW-1:0]  word_b;
    logic              vector_ok;
    cnt_sel_e          cnt_sel;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_SUMMARY
  } back_state_e;

endpackage

// ===== rtl/edt_front.sv =====
// ----------------------------------------------------------------------------
// Exception dispatch table front end
// Holds the configuration registers and classifies each item into a command.
// ----------------------------------------------------------------------------
module edt_front
  import edt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CodeW-1:0]   cfg_data_i,
  input  logic               func_i,
  input  logic [CodeW-1:0]   entry_code_i,
  input  logic [WordW-1:0]   entry_mask_a_i,
  input  logic [WordW-1:0]   entry_mask_b_i,
  input  logic [1:0]         exc_type_i,
  input  logic [CodeW-1:0]   event_code_i,
  input  logic [CodeW-1:0]   irq_event_code_i,
  input  logic [WordW-1:0]   irq_status_a_i,
  input  logic [WordW-1:0]   irq_status_b_i,
  output cmd_t               cmd_o
);

  logic [CodeW-1:0] user_break_q;
  logic [CodeW-1:0] unknown_type_q;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_break_q   <= UserBreakReset;
      unknown_type_q <= UnknownTypeReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_USER_BREAK) begin
        user_break_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_UNKNOWN_TYPE) begin
        unknown_type_q <= cfg_data_i;
      end
    end
  end

  // Classify the item
  always_comb begin
    cmd_o.func      = func_e'(func_i);
    cmd_o.code      = entry_code_i;
    cmd_o.word_a    = entry_mask_a_i;
    cmd_o.word_b    = entry_mask_b_i;
    cmd_o.vector_ok = 1'b1;
    cmd_o.cnt_sel   = CNT_GENERAL;
    if (func_e'(func_i) == FUNC_DISPATCH) begin
      cmd_o.word_a = irq_status_a_i;
      cmd_o.word_b = irq_status_b_i;
      unique case (exc_type_e'(exc_type_i))
        EXC_GENERAL: begin
          cmd_o.code = event_code_i;
          if (event_code_i == user_break_q) begin
            cmd_o.cnt_sel   = CNT_GENERAL_BREAK;
            cmd_o.vector_ok = 1'b0;
          end
        end
        EXC_CACHE: begin
          cmd_o.code    = event_code_i;
          cmd_o.cnt_sel = CNT_CACHE;
        end
        EXC_INTERRUPT: begin
          cmd_o.code    = irq_event_code_i;
          cmd_o.cnt_sel = CNT_INTERRUPT;
        end
        EXC_UNKNOWN: begin
          cmd_o.code      = unknown_type_q;
          cmd_o.cnt_sel   = CNT_ODD;
          cmd_o.vector_ok = 1'b0;
        end
        default: begin
          cmd_o.code = event_code_i;
        end
      endcase
    end
  end

endmodule

// ===== rtl/edt_queue.sv =====
// ----------------------------------------------------------------------------
// Exception dispatch table command queue
// Short FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
module edt_queue
  import edt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned PtrW = (CmdQueueDepth > 1) ? $clog2(CmdQueueDepth) : 1;
  localparam int unsigned CntW = $clog2(CmdQueueDepth + 1);

  cmd_t            buf_q [CmdQueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(CmdQueueDepth));
  assign cmd_o   = buf_q[rd_ptr_q];

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(CmdQueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(CmdQueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/edt_back.sv =====
// ----------------------------------------------------------------------------
// Exception dispatch table back end
// Owns the handler table and counters; scans one slot per cycle per command.
// ----------------------------------------------------------------------------
module edt_back
  import edt_pkg::*;
#(
  parameter int unsigned TableEntries = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             pop_o,
  output logic             res_valid_o,
  output logic [KindW-1:0] kind_o,
  output logic [SlotW-1:0] slot_o,
  output logic [CodeW-1:0] matched_code_o,
  output logic [WordW-1:0] masked_a_o,
  output logic [WordW-1:0] masked_b_o,
  output logic             vector_ok_o,
  output logic             last_o,
  output logic [WordW-1:0] general_count_o,
  output logic [WordW-1:0] break_count_o,
  output logic [WordW-1:0] cache_count_o,
  output logic [WordW-1:0] interrupt_count_o,
  output logic [WordW-1:0] odd_count_o
);

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  back_state_e      state_q, state_d;
  cmd_t             cmd_q;
  logic [IdxW-1:0]  idx_q, idx_d;

  logic [CodeW-1:0] codes_q  [TableEntries];
  logic [WordW-1:0] masks_a_q[TableEntries];
  logic [WordW-1:0] masks_b_q[TableEntries];

  logic [WordW-1:0] gen_cnt_q, brk_cnt_q, cache_cnt_q, irq_cnt_q, odd_cnt_q;

  logic             tbl_we;
  logic             res_valid_d, res_valid_q;
  kind_e            kind_d, kind_q;
  logic [SlotW-1:0] slot_d, slot_q;
  logic [CodeW-1:0] code_d, code_q;
  logic [WordW-1:0] ma_d, ma_q, mb_d, mb_q;
  logic             ok_d, ok_q, last_d, last_q;

  logic [CodeW-1:0] cur_code;
  logic [WordW-1:0] cur_ma, cur_mb, and_a, and_b;
  logic             hit, at_end;

  // Current slot under scan
  assign cur_code = codes_q[idx_q];
  assign cur_ma   = masks_a_q[idx_q];
  assign cur_mb   = masks_b_q[idx_q];
  assign and_a    = cur_ma & cmd_q.word_a;
  assign and_b    = cur_mb & cmd_q.word_b;
  assign hit      = (cur_code != '0) && (cur_code == cmd_q.code) &&
                    (((cur_ma | cur_mb) == '0) || ((and_a | and_b) != '0));
  assign at_end   = (idx_q == IdxW'(TableEntries - 1));

  // Sequencer: next state and result
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    tbl_we      = 1'b0;
    res_valid_d = 1'b0;
    kind_d      = KIND_REG_REPLY;
    slot_d      = '0;
    code_d      = '0;
    ma_d        = '0;
    mb_d        = '0;
    ok_d        = 1'b0;
    last_d      = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          pop_o   = 1'b1;
          idx_d   = '0;
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (cmd_q.func == FUNC_REGISTER) begin
          if (cur_code == '0) begin
            tbl_we      = 1'b1;
            res_valid_d = 1'b1;
            slot_d      = SlotW'(idx_q) + 1'b1;
            last_d      = 1'b1;
            state_d     = BK_IDLE;
          end else if (at_end) begin
            res_valid_d = 1'b1;
            last_d      = 1'b1;
            state_d     = BK_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          if (hit) begin
            res_valid_d = 1'b1;
            kind_d      = KIND_MATCH;
            slot_d      = SlotW'(idx_q);
            code_d      = cmd_q.code;
            ma_d        = and_a;
            mb_d        = and_b;
            ok_d        = cmd_q.vector_ok;
          end
          if (at_end) begin
            state_d = BK_SUMMARY;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      BK_SUMMARY: begin
        res_valid_d = 1'b1;
        kind_d      = KIND_SUMMARY;
        code_d      = cmd_q.code;
        ok_d        = cmd_q.vector_ok;
        last_d      = 1'b1;
        state_d     = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Control registers and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
      gen_cnt_q   <= '0;
      brk_cnt_q   <= '0;
      cache_cnt_q <= '0;
      irq_cnt_q   <= '0;
      odd_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
      if (pop_o && cmd_i.func == FUNC_DISPATCH) begin
        unique case (cmd_i.cnt_sel)
          CNT_GENERAL:       gen_cnt_q <= gen_cnt_q + 1'b1;
          CNT_GENERAL_BREAK: begin
            gen_cnt_q <= gen_cnt_q + 1'b1;
            brk_cnt_q <= brk_cnt_q + 1'b1;
          end
          CNT_CACHE:         cache_cnt_q <= cache_cnt_q + 1'b1;
          CNT_INTERRUPT:     irq_cnt_q <= irq_cnt_q + 1'b1;
          CNT_ODD:           odd_cnt_q <= odd_cnt_q + 1'b1;
          default:           ;
        endcase
      end
    end
  end

  // Entry codes clear on reset, so every slot starts free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TableEntries; i++) begin
        codes_q[i] <= '0;
      end
    end else if (tbl_we) begin
      codes_q[idx_q] <= cmd_q.code;
    end
  end

  // Masks of a free slot are never reported, so they need no reset
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      masks_a_q[idx_q] <= cmd_q.word_a;
      masks_b_q[idx_q] <= cmd_q.word_b;
    end
  end

  // Hold the popped command and the result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    kind_q <= kind_d;
    slot_q <= slot_d;
    code_q <= code_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    ok_q   <= ok_d;
    last_q <= last_d;
  end

  assign res_valid_o    = res_valid_q;
  assign kind_o         = kind_q;
  assign slot_o         = slot_q;
  assign matched_code_o = code_q;
  assign masked_a_o     = ma_q;
  assign masked_b_o     = mb_q;
  assign vector_ok_o    = ok_q;
  assign last_o         = last_q;

  // Counters change only at a pop, which is never earlier than the edge
  // that ends a result cycle, so they are shown straight from the registers
  assign general_count_o   = gen_cnt_q;
  assign break_count_o     = brk_cnt_q;
  assign cache_count_o     = cache_cnt_q;
  assign interrupt_count_o = irq_cnt_q;
  assign odd_count_o       = odd_cnt_q;

endmodule

// ===== rtl/exception_dispatch_table_core.sv =====
// ----------------------------------------------------------------------------
// Exception dispatch table core
// Handler table with register and dispatch commands and event counters.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; the front end
// classifies it and puts it in a two-entry command queue, so busy rises
// only when two commands are waiting. The back end runs one command at a
// time and scans the table one slot per cycle: a dispatch pops the queue,
// checks every slot and then gives its summary, and a register item pops
// the queue and scans up to the first free slot, or to the end of a full
// table. Results appear on the result ports for one cycle each, marked
// by result_valid_o, and cannot be held off; last_o marks the final result
// of an item. Configuration writes are always accepted (cfg_ready_o high).
// ----------------------------------------------------------------------------
module exception_dispatch_table_core
  import edt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CodeW-1:0]   cfg_data_i,
  input  logic               start,
  output logic               busy,
  input  logic               func_i,
  input  logic [CodeW-1:0]   entry_code_i,
  input  logic [WordW-1:0]   entry_mask_a_i,
  input  logic [WordW-1:0]   entry_mask_b_i,
  input  logic [1:0]         exc_type_i,
  input  logic [CodeW-1:0]   event_code_i,
  input  logic [CodeW-1:0]   irq_event_code_i,
  input  logic [WordW-1:0]   irq_status_a_i,
  input  logic [WordW-1:0]   irq_status_b_i,
  output logic               result_valid_o,
  output logic [KindW-1:0]   kind_o,
  output logic [SlotW-1:0]   slot_o,
  output logic [CodeW-1:0]   matched_code_o,
  output logic [WordW-1:0]   masked_a_o,
  output logic [WordW-1:0]   masked_b_o,
  output logic               vector_ok_o,
  output logic               last_o,
  output logic [WordW-1:0]   general_count_o,
  output logic [WordW-1:0]   break_count_o,
  output logic [WordW-1:0]   cache_count_o,
  output logic [WordW-1:0]   interrupt_count_o,
  output logic [WordW-1:0]   odd_count_o
);

  cmd_t front_cmd, queue_cmd;
  logic q_empty, q_full, q_pop, q_push;

  assign cfg_ready_o = 1'b1;
  assign busy        = q_full;
  assign q_push      = start && !q_full;

  edt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (func_i),
    .entry_code_i    (entry_code_i),
    .entry_mask_a_i  (entry_mask_a_i),
    .entry_mask_b_i  (entry_mask_b_i),
    .exc_type_i      (exc_type_i),
    .event_code_i    (event_code_i),
    .irq_event_code_i(irq_event_code_i),
    .irq_status_a_i  (irq_status_a_i),
    .irq_status_b_i  (irq_status_b_i),
    .cmd_o           (front_cmd)
  );

  edt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (front_cmd),
    .pop_i  (q_pop),
    .cmd_o  (queue_cmd),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  edt_back #(
    .TableEntries(TABLE_ENTRIES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (!q_empty),
    .cmd_i            (queue_cmd),
    .pop_o            (q_pop),
    .res_valid_o      (result_valid_o),
    .kind_o           (kind_o),
    .slot_o           (slot_o),
    .matched_code_o   (matched_code_o),
    .masked_a_o       (masked_a_o),
    .masked_b_o       (masked_b_o),
    .vector_ok_o      (vector_ok_o),
    .last_o           (last_o),
    .general_count_o  (general_count_o),
    .break_count_o    (break_count_o),
    .cache_count_o    (cache_count_o),
    .interrupt_count_o(interrupt_count_o),
    .odd_count_o      (odd_count_o)
  );

endmodule

// ===== tb/sv/exception_dispatch_table_core_tb.sv =====
// ----------------------------------------------------------------------------
// Exception dispatch table core testbench
// Drives register and dispatch commands through the start/busy handshake.
// Each transfer is predicted against a local copy of the handler table,
// the counters and the two code registers. Every strobed result is compared
// field by field in order against the predicted results.
// ----------------------------------------------------------------------------
module exception_dispatch_table_core_tb
  import edt_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TableEntries = 16;
  localparam time         ClkPeriod    = 10ns;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned DrainCap     = 4000;
  localparam int unsigned GapPct       = 29;
  localparam logic [CodeW-1:0] FullCode = 12'h3C3;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  // One command as presented on the input ports
  typedef struct {
    func_e            func;
    logic [CodeW-1:0] entry_code;
    logic [WordW-1:0] entry_mask_a;
    logic [WordW-1:0] entry_mask_b;
    exc_type_e        exc;
    logic [CodeW-1:0] evt;
    logic [CodeW-1:0] irq_evt;
    logic [WordW-1:0] status_a;
    logic [WordW-1:0] status_b;
  } table_cmd_t;

  // One result as seen on the output ports
  typedef struct {
    kind_e            kind;
    logic [SlotW-1:0] slot;
    logic [CodeW-1:0] code;
    logic [WordW-1:0] masked_a;
    logic [WordW-1:0] masked_b;
    logic             vector_ok;
    logic             last;
    logic [WordW-1:0] cnt_general;
    logic [WordW-1:0] cnt_break;
    logic [WordW-1:0] cnt_cache;
    logic [WordW-1:0] cnt_irq;
    logic [WordW-1:0] cnt_odd;
  } table_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CodeW-1:0]   cfg_data_i;
  logic               start;
  logic               busy;
  logic               func_i;
  logic [CodeW-1:0]   entry_code_i;
  logic [WordW-1:0]   entry_mask_a_i;
  logic [WordW-1:0]   entry_mask_b_i;
  logic [1:0]         exc_type_i;
  logic [CodeW-1:0]   event_code_i;
  logic [CodeW-1:0]   irq_event_code_i;
  logic [WordW-1:0]   irq_status_a_i;
  logic [WordW-1:0]   irq_status_b_i;
  logic               result_valid_o;
  logic [KindW-1:0]   kind_o;
  logic [SlotW-1:0]   slot_o;
  logic [CodeW-1:0]   matched_code_o;
  logic [WordW-1:0]   masked_a_o;
  logic [WordW-1:0]   masked_b_o;
  logic               vector_ok_o;
  logic               last_o;
  logic [WordW-1:0]   general_count_o;
  logic [WordW-1:0]   break_count_o;
  logic [WordW-1:0]   cache_count_o;
  logic [WordW-1:0]   interrupt_count_o;
  logic [WordW-1:0]   odd_count_o;

  // Local copy of the table, counters and code registers
  logic [CodeW-1:0] tbl_code   [TableEntries];
  logic [WordW-1:0] tbl_mask_a [TableEntries];
  logic [WordW-1:0] tbl_mask_b [TableEntries];
  logic [WordW-1:0] n_general, n_break, n_cache, n_irq, n_odd;
  logic [CodeW-1:0] break_code_cfg, unknown_code_cfg;

  table_result_t awaited_results[$];
  int            fail_count  = 0;
  int unsigned   cycle_count = 0;
  int unsigned   gap_pct     = GapPct;

  exception_dispatch_table_core #(
    .TABLE_ENTRIES(TableEntries)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .entry_code_i     (entry_code_i),
    .entry_mask_a_i   (entry_mask_a_i),
    .entry_mask_b_i   (entry_mask_b_i),
    .exc_type_i       (exc_type_i),
    .event_code_i     (event_code_i),
    .irq_event_code_i (irq_event_code_i),
    .irq_status_a_i   (irq_status_a_i),
    .irq_status_b_i   (irq_status_b_i),
    .result_valid_o   (result_valid_o),
    .kind_o           (kind_o),
    .slot_o           (slot_o),
    .matched_code_o   (matched_code_o),
    .masked_a_o       (masked_a_o),
    .masked_b_o       (masked_b_o),
    .vector_ok_o      (vector_ok_o),
    .last_o           (last_o),
    .general_count_o  (general_count_o),
    .break_count_o    (break_count_o),
    .cache_count_o    (cache_count_o),
    .interrupt_count_o(interrupt_count_o),
    .odd_count_o      (odd_count_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  task automatic push_expected(input kind_e kind, input logic [SlotW-1:0] slot,
                               input logic [CodeW-1:0] code,
                               input logic [WordW-1:0] ma, input logic [WordW-1:0] mb,
                               input logic ok, input logic last);
    table_result_t r;
    r.kind        = kind;
    r.slot        = slot;
    r.code        = code;
    r.masked_a    = ma;
    r.masked_b    = mb;
    r.vector_ok   = ok;
    r.last        = last;
    r.cnt_general = n_general;
    r.cnt_break   = n_break;
    r.cnt_cache   = n_cache;
    r.cnt_irq     = n_irq;
    r.cnt_odd     = n_odd;
    awaited_results.push_back(r);
  endtask

  // Apply one accepted command to the local table and queue its results
  task automatic predict_table_item(input table_cmd_t c);
    logic [CodeW-1:0] sel_code;
    logic [WordW-1:0] hit_a, hit_b;
    logic             ok;
    int               free_idx;
    ok       = 1'b1;
    free_idx = -1;
    sel_code = '0;
    if (c.func == FUNC_REGISTER) begin
      for (int i = 0; i < TableEntries; i++) begin
        if (free_idx < 0 && tbl_code[i] == '0) free_idx = i;
      end
      if (free_idx >= 0) begin
        // a zero code still writes the masks but leaves the slot free
        tbl_code[free_idx]   = c.entry_code;
        tbl_mask_a[free_idx] = c.entry_mask_a;
        tbl_mask_b[free_idx] = c.entry_mask_b;
        push_expected(KIND_REG_REPLY, SlotW'(free_idx + 1), '0, '0, '0, 1'b0, 1'b1);
      end else begin
        push_expected(KIND_REG_REPLY, '0, '0, '0, '0, 1'b0, 1'b1);
      end
    end else begin
      // select the event code and bump the counters
      case (c.exc)
        EXC_GENERAL: begin
          n_general = n_general + 1'b1;
          sel_code  = c.evt;
          if (sel_code == break_code_cfg) begin
            n_break = n_break + 1'b1;
            ok      = 1'b0;
          end
        end
        EXC_CACHE: begin
          n_cache  = n_cache + 1'b1;
          sel_code = c.evt;
        end
        EXC_INTERRUPT: begin
          n_irq    = n_irq + 1'b1;
          sel_code = c.irq_evt;
        end
        default: begin
          n_odd    = n_odd + 1'b1;
          sel_code = unknown_code_cfg;
          ok       = 1'b0;
        end
      endcase
      // scan occupied slots in order
      for (int i = 0; i < TableEntries; i++) begin
        hit_a = tbl_mask_a[i] & c.status_a;
        hit_b = tbl_mask_b[i] & c.status_b;
        if (tbl_code[i] != '0 && tbl_code[i] == sel_code &&
            (((tbl_mask_a[i] | tbl_mask_b[i]) == '0) || ((hit_a | hit_b) != '0))) begin
          push_expected(KIND_MATCH, SlotW'(i), sel_code, hit_a, hit_b, ok, 1'b0);
        end
      end
      push_expected(KIND_SUMMARY, '0, sel_code, '0, '0, ok, 1'b1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [WordW-1:0] expv,
                             input logic [WordW-1:0] actv);
    if (expv !== actv) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    table_result_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (awaited_results.size() == 0) begin
        $error("result with none outstanding: kind %0d slot %0d", kind_o, slot_o);
        fail_count++;
      end else begin
        exp_r = awaited_results.pop_front();
        check_field("kind",            exp_r.kind,        kind_o);
        check_field("slot",            exp_r.slot,        slot_o);
        check_field("matched_code",    exp_r.code,        matched_code_o);
        check_field("masked_a",        exp_r.masked_a,    masked_a_o);
        check_field("masked_b",        exp_r.masked_b,    masked_b_o);
        check_field("vector_ok",       exp_r.vector_ok,   vector_ok_o);
        check_field("last",            exp_r.last,        last_o);
        check_field("general_count",   exp_r.cnt_general, general_count_o);
        check_field("break_count",     exp_r.cnt_break,   break_count_o);
        check_field("cache_count",     exp_r.cnt_cache,   cache_count_o);
        check_field("interrupt_count", exp_r.cnt_irq,     interrupt_count_o);
        check_field("odd_count",       exp_r.cnt_odd,     odd_count_o);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Small set of codes so that entries collide and dispatches hit
  function automatic logic [CodeW-1:0] hot_code(input int unsigned k);
    case (k)
      0:       return 12'h1E0;
      1:       return 12'hFFF;
      2:       return 12'h001;
      3:       return 12'h800;
      default: return FullCode;
    endcase
  endfunction

  function automatic logic [CodeW-1:0] pick_code();
    if ($urandom_range(99) < 65) return hot_code($urandom_range(4));
    return CodeW'($urandom);
  endfunction

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return WordW'(1) << $urandom_range(WordW - 1);
      default: return $urandom;
    endcase
  endfunction

  function automatic table_cmd_t make_register(input logic [CodeW-1:0] code,
                                               input logic [WordW-1:0] ma,
                                               input logic [WordW-1:0] mb);
    table_cmd_t c;
    c.func         = FUNC_REGISTER;
    c.entry_code   = code;
    c.entry_mask_a = ma;
    c.entry_mask_b = mb;
    c.exc          = exc_type_e'($urandom_range(3));
    c.evt          = CodeW'($urandom);
    c.irq_evt      = CodeW'($urandom);
    c.status_a     = $urandom;
    c.status_b     = $urandom;
    return c;
  endfunction

  function automatic table_cmd_t make_dispatch(input exc_type_e exc,
                                               input logic [CodeW-1:0] evt,
                                               input logic [CodeW-1:0] irq_evt,
                                               input logic [WordW-1:0] sa,
                                               input logic [WordW-1:0] sb);
    table_cmd_t c;
    c.func         = FUNC_DISPATCH;
    c.entry_code   = CodeW'($urandom);
    c.entry_mask_a = $urandom;
    c.entry_mask_b = $urandom;
    c.exc          = exc;
    c.evt          = evt;
    c.irq_evt      = irq_evt;
    c.status_a     = sa;
    c.status_b     = sb;
    return c;
  endfunction

  // Present one command, hold it until the transfer, then predict it
  task automatic send_table_item(input table_cmd_t c);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2 * TableEntries)) @(posedge clk_i);
    end
    start            <= 1'b1;
    func_i           <= c.func;
    entry_code_i     <= c.entry_code;
    entry_mask_a_i   <= c.entry_mask_a;
    entry_mask_b_i   <= c.entry_mask_b;
    exc_type_i       <= c.exc;
    event_code_i     <= c.evt;
    irq_event_code_i <= c.irq_evt;
    irq_status_a_i   <= c.status_a;
    irq_status_b_i   <= c.status_b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_table_item(c);
  endtask

  // Drop start and hold off until every outstanding result has arrived
  task automatic drain_results();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write one register; the caller drops valid after its last write
  task automatic write_table_cfg(input logic [CfgIdxW-1:0] idx,
                                 input logic [CodeW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_USER_BREAK) break_code_cfg = val;
    else if (idx == CFG_UNKNOWN_TYPE) unknown_code_cfg = val;
  endtask

  task automatic program_codes(input logic [CodeW-1:0] user_break,
                               input logic [CodeW-1:0] unknown_type);
    drain_results();
    write_table_cfg(CFG_USER_BREAK, user_break);
    write_table_cfg(CFG_UNKNOWN_TYPE, unknown_type);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Free slots never match, even for code zero and with masks written
  task automatic test_free_slots();
    send_table_item(make_dispatch(EXC_GENERAL, '0, '0, '1, '1));
    send_table_item(make_register('0, '1, '1));
    send_table_item(make_dispatch(EXC_CACHE, '0, '1, '1, '1));
  endtask

  // Fill a few slots and hit them through every exception type
  task automatic test_register_and_match();
    send_table_item(make_register(12'hFFF, '0, '0));
    send_table_item(make_register(12'h1E0, 32'hFFFF_FFFF, '0));
    send_table_item(make_register(12'h001, '0, 32'h8000_0000));
    send_table_item(make_register(12'h001, '0, '0));
    send_table_item(make_dispatch(EXC_UNKNOWN, 12'h1E0, 12'h001, '0, '0));
    send_table_item(make_dispatch(EXC_GENERAL, 12'h1E0, 12'hFFF, 32'h1, '0));
    send_table_item(make_dispatch(EXC_CACHE, 12'h1E0, 12'h001, 32'h1, '0));
    send_table_item(make_dispatch(EXC_INTERRUPT, 12'hFFF, 12'h001, '0, 32'h8000_0000));
    send_table_item(make_dispatch(EXC_INTERRUPT, '0, 12'h001, '1, 32'h7FFF_FFFF));
    send_table_item(make_dispatch(EXC_GENERAL, 12'h001, 12'h1E0, '1, '1));
  endtask

  // Code registers at both extremes; spare indexes must be ignored
  task automatic test_code_registers();
    program_codes('0, '0);
    write_table_cfg(CfgSpareLo, '1);
    write_table_cfg(CfgSpareHi, 12'hAAA);
    cfg_valid_i <= 1'b0;
    send_table_item(make_dispatch(EXC_GENERAL, '0, '1, '1, '1));
    send_table_item(make_dispatch(EXC_UNKNOWN, '1, '1, '1, '1));
    program_codes('1, 12'h001);
    send_table_item(make_dispatch(EXC_GENERAL, 12'hFFF, '0, '0, '0));
    send_table_item(make_dispatch(EXC_UNKNOWN, '0, '0, '0, 32'h8000_0000));
  endtask

  // Mixed traffic with occasional reprogramming and a stretch without gaps
  task automatic test_random_traffic(input int unsigned n_items);
    table_cmd_t  c;
    int unsigned reg_pct;
    for (int unsigned k = 0; k < n_items; k++) begin
      gap_pct = (k >= n_items / 3 && k < n_items / 3 + 50) ? 0 : GapPct;
      if (k == n_items / 4) program_codes(hot_code($urandom_range(4)),
                                          hot_code($urandom_range(4)));
      if (k == (3 * n_items) / 4) program_codes(CodeW'($urandom), pick_code());
      if (k % 60 == 59) drain_results();
      reg_pct = 8;
      for (int i = 0; i < TableEntries; i++) begin
        if (tbl_code[i] == '0) reg_pct = 25;
      end
      if ($urandom_range(99) < reg_pct) begin
        c = make_register(($urandom_range(9) == 0) ? '0 : pick_code(),
                          pick_word(), pick_word());
      end else begin
        c = make_dispatch(exc_type_e'($urandom_range(3)), pick_code(), pick_code(),
                          pick_word(), pick_word());
      end
      send_table_item(c);
    end
    gap_pct = GapPct;
  endtask

  // Fill what is left with one code, overflow the table, hit every slot with that code
  task automatic test_table_full();
    int unsigned free_left;
    free_left = 0;
    for (int i = 0; i < TableEntries; i++) begin
      if (tbl_code[i] == '0) free_left++;
    end
    for (int unsigned k = 0; k < free_left; k++) begin
      send_table_item(make_register(FullCode, (k % 2 == 0) ? '0 : $urandom, $urandom));
    end
    send_table_item(make_register(FullCode, '1, '1));
    send_table_item(make_register('0, '0, '0));
    send_table_item(make_dispatch(EXC_CACHE, FullCode, '0, '1, '1));
    send_table_item(make_dispatch(EXC_INTERRUPT, '0, FullCode, $urandom, $urandom));
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_ni           <= 1'b0;
    cfg_valid_i      <= 1'b0;
    cfg_index_i      <= '0;
    cfg_data_i       <= '0;
    start            <= 1'b0;
    func_i           <= 1'b0;
    entry_code_i     <= '0;
    entry_mask_a_i   <= '0;
    entry_mask_b_i   <= '0;
    exc_type_i       <= '0;
    event_code_i     <= '0;
    irq_event_code_i <= '0;
    irq_status_a_i   <= '0;
    irq_status_b_i   <= '0;
    for (int i = 0; i < TableEntries; i++) begin
      tbl_code[i]   = '0;
      tbl_mask_a[i] = '0;
      tbl_mask_b[i] = '0;
    end
    n_general        = '0;
    n_break          = '0;
    n_cache          = '0;
    n_irq            = '0;
    n_odd            = '0;
    break_code_cfg   = UserBreakReset;
    unknown_code_cfg = UnknownTypeReset;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_free_slots();
    test_register_and_match();
    test_code_registers();
    test_random_traffic(175);
    drain_results();
    test_table_full();

    // let the last results out, then check nothing was left behind
    start <= 1'b0;
    for (int w = 0; w < DrainCap && awaited_results.size() != 0; w++) @(posedge clk_i);
    repeat (TableEntries + 4) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      $error("%0d expected results never arrived", awaited_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
